[rtl/fat_cluster_table_engine_top_macros.svh]
// Assertion macros for the FAT cluster table engine.
// Used by the RTL files that carry assertions; expects clk and arst_n in scope.
`ifndef FAT_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH
`define FAT_CLUSTER_TABLE_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define FCTE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define FCTE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define FCTE_ASSERT(lbl, prop, msg)
`define FCTE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[rtl/fcte_pkg.sv]
// Shared constants, codes and controller/datapath types of the FAT cluster table engine.
// No dependencies; every other RTL file except the assertion macro header imports it.
`default_nettype none

package fcte_pkg;

	localparam int CLUSTERS     = 4096;
	localparam int CL_W         = $clog2(CLUSTERS);
	localparam int CNT_W        = $clog2(CLUSTERS + 1);
	localparam int LINK_W       = 28;
	localparam int ENTRY_W      = 32;
	localparam int OP_W         = 3;
	localparam int STATUS_W     = 2;
	localparam int ALLOC_W      = 12;
	localparam int CS_W         = 8;
	localparam int BYTES_W      = 29;
	localparam int SECTOR_SHIFT = 9;
	localparam int PROD_W       = CNT_W + CS_W;
	localparam int FULL_W       = PROD_W + SECTOR_SHIFT;

	localparam logic [ENTRY_W-1:0] TOP_MASK     = 32'hF000_0000;
	localparam logic [ENTRY_W-1:0] END_MARK     = 32'h0FFF_FFFF;
	localparam logic [LINK_W-1:0]  END_MIN_LINK = 28'hFFF_FFF8;
	localparam logic [BYTES_W-1:0] BYTES_MAX    = 29'h1FFF_FFFF;

	typedef enum logic [OP_W-1:0] {
		OP_READ       = 3'd0,
		OP_SET        = 3'd1,
		OP_FREE       = 3'd2,
		OP_ALLOC      = 3'd3,
		OP_FREE_CHAIN = 3'd4,
		OP_CHAIN_SIZE = 3'd5
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NO_FREE = 2'd2,
		ST_LOOP    = 2'd3
	} status_t;

	typedef struct packed {
		logic    take;       // req ready
		logic    load;       // capture request word
		logic    clr_wr;     // clearing pass write
		logic    rd_cl;      // read addressed entry
		logic    wr_set;     // write new link, keep top bits
		logic    wr_free;    // zero addressed entry
		logic    scan_rd;    // allocate scan read
		logic    alloc_wr;   // mark found entry end of chain
		logic    walk_rd;    // read current chain entry
		logic    walk_step;  // advance chain walk
		logic    link_cap;   // capture read link
		logic    set_st;
		status_t st;
		logic    res_load;   // load result register
	} cmd_t;

	typedef struct packed {
		logic            req_valid;
		logic            out_free;
		logic            clr_last;
		logic [OP_W-1:0] op;
		logic            cl_valid;
		logic            scan_free;
		logic            scan_last;
		logic            cur_end;
		logic            cur_valid;
		logic            n_full;
	} stat_t;

endpackage

`default_nettype wire

[rtl/fcte_if.sv]
// Handshake channel interfaces of the FAT cluster table engine: request, result, config.
// Depends on fcte_pkg.
`default_nettype none

interface fcte_req_if;
	import fcte_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [LINK_W-1:0] cluster;
	logic [LINK_W-1:0] new_link;
	modport source (output valid, output opcode, output cluster, output new_link, input ready);
	modport sink (input valid, input opcode, input cluster, input new_link, output ready);
endinterface

interface fcte_rsp_if;
	import fcte_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [LINK_W-1:0]   link_value;
	logic [ALLOC_W-1:0]  allocated;
	logic [CNT_W-1:0]    chain_count;
	logic [BYTES_W-1:0]  chain_bytes;
	modport source (output valid, output status, output link_value, output allocated,
		output chain_count, output chain_bytes, input ready);
	modport sink (input valid, input status, input link_value, input allocated,
		input chain_count, input chain_bytes, output ready);
endinterface

interface fcte_cfg_if;
	import fcte_pkg::*;
	logic            valid;
	logic            ready;
	logic [CS_W-1:0] cluster_sectors;
	modport source (output valid, output cluster_sectors, input ready);
	modport sink (input valid, input cluster_sectors, output ready);
endinterface

`default_nettype wire

[rtl/fcte_dpath.sv]
// Datapath of the FAT cluster table engine: table memory, walk/scan registers, result register.
// Depends on fcte_pkg, fcte_if and the assertion macro header.
`default_nettype none
`include "fat_cluster_table_engine_top_macros.svh"

module fcte_dpath (
	input  logic            clk,
	input  logic            arst_n,
	fcte_req_if.sink        req,
	fcte_rsp_if.source      rsp,
	fcte_cfg_if.sink        cfg,
	input  fcte_pkg::cmd_t  cmd,
	output fcte_pkg::stat_t stat
);
	import fcte_pkg::*;

	logic [ENTRY_W-1:0]  fat_q [CLUSTERS];
	logic [ENTRY_W-1:0]  rdata_s1;
	logic [CL_W-1:0]     rd_addr_s1;

	logic [OP_W-1:0]     op_q;
	logic [LINK_W-1:0]   cl_q;
	logic [LINK_W-1:0]   nl_q;
	logic [LINK_W-1:0]   cur_q;
	logic [CNT_W-1:0]    n_q;
	logic [CL_W-1:0]     ptr_q;
	logic [CS_W-1:0]     cs_q;
	status_t             status_q;
	logic [LINK_W-1:0]   link_q;
	logic [ALLOC_W-1:0]  alloc_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [LINK_W-1:0]   out_link_q;
	logic [ALLOC_W-1:0]  out_alloc_q;
	logic [CNT_W-1:0]    out_count_q;
	logic [BYTES_W-1:0]  out_bytes_q;

	logic                we;
	logic [CL_W-1:0]     waddr;
	logic [ENTRY_W-1:0]  wdata;
	logic                re;
	logic [CL_W-1:0]     raddr;

	logic [PROD_W-1:0]   prod;
	logic [FULL_W-1:0]   bytes_full;
	logic [BYTES_W-1:0]  bytes_sat;

	// single write port
	always_comb begin
		we    = 1'b0;
		waddr = cl_q[CL_W-1:0];
		wdata = '0;
		if (cmd.clr_wr) begin
			we    = 1'b1;
			waddr = ptr_q;
		end else if (cmd.wr_set) begin
			we    = 1'b1;
			wdata = (rdata_s1 & TOP_MASK) | ENTRY_W'(nl_q);
		end else if (cmd.wr_free) begin
			we = 1'b1;
		end else if (cmd.alloc_wr) begin
			we    = 1'b1;
			waddr = rd_addr_s1;
			wdata = END_MARK;
		end else if (cmd.walk_step && op_q == OP_FREE_CHAIN) begin
			// link already captured from rdata, entry freed behind the walk
			we    = 1'b1;
			waddr = rd_addr_s1;
		end
	end

	// single read port
	always_comb begin
		re    = 1'b0;
		raddr = cl_q[CL_W-1:0];
		if (cmd.rd_cl) begin
			re = 1'b1;
		end else if (cmd.scan_rd) begin
			re    = 1'b1;
			raddr = ptr_q;
		end else if (cmd.walk_rd) begin
			re    = 1'b1;
			raddr = cur_q[CL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			fat_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1   <= fat_q[raddr];
			rd_addr_s1 <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cs_q  <= CS_W'(1);
			n_q   <= '0;
		end else begin
			if (cfg.valid) begin
				cs_q <= cfg.cluster_sectors;
			end
			if (cmd.load) begin
				ptr_q <= CL_W'(2);
			end else if (cmd.clr_wr || cmd.scan_rd) begin
				ptr_q <= ptr_q + CL_W'(1);
			end
			if (cmd.load) begin
				n_q <= '0;
			end else if (cmd.walk_step) begin
				n_q <= n_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= req.opcode;
			cl_q     <= req.cluster;
			nl_q     <= req.new_link;
			cur_q    <= req.cluster;
			status_q <= ST_OK;
			link_q   <= '0;
			alloc_q  <= '0;
		end else begin
			if (cmd.walk_step) begin
				cur_q <= rdata_s1[LINK_W-1:0];
			end
			if (cmd.set_st) begin
				status_q <= cmd.st;
			end
			if (cmd.link_cap) begin
				link_q <= rdata_s1[LINK_W-1:0];
			end
			if (cmd.alloc_wr) begin
				alloc_q <= ALLOC_W'(rd_addr_s1);
			end
		end
	end

	// bytes = count * 512 * sectors, saturated
	assign prod       = PROD_W'(n_q) * PROD_W'(cs_q);
	assign bytes_full = {prod, {SECTOR_SHIFT{1'b0}}};
	assign bytes_sat  = (bytes_full > FULL_W'(BYTES_MAX)) ? BYTES_MAX
		: bytes_full[BYTES_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status_q <= status_q;
			out_link_q   <= link_q;
			out_alloc_q  <= alloc_q;
			out_count_q  <= n_q;
			out_bytes_q  <= bytes_sat;
		end
	end

	assign req.ready       = cmd.take;
	assign cfg.ready       = 1'b1;
	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.link_value  = out_link_q;
	assign rsp.allocated   = out_alloc_q;
	assign rsp.chain_count = out_count_q;
	assign rsp.chain_bytes = out_bytes_q;

	assign stat.req_valid = req.valid;
	assign stat.out_free  = !out_valid_q || rsp.ready;
	assign stat.clr_last  = ptr_q == CL_W'(CLUSTERS - 1);
	assign stat.op        = op_q;
	assign stat.cl_valid  = cl_q >= LINK_W'(2) && cl_q < LINK_W'(CLUSTERS);
	assign stat.scan_free = rdata_s1[LINK_W-1:0] == '0;
	assign stat.scan_last = rd_addr_s1 == CL_W'(CLUSTERS - 1);
	assign stat.cur_end   = cur_q >= END_MIN_LINK;
	assign stat.cur_valid = cur_q >= LINK_W'(2) && cur_q < LINK_W'(CLUSTERS);
	assign stat.n_full    = n_q >= CNT_W'(CLUSTERS);

	`FCTE_ASSERT(a_no_rsp_overwrite, !(cmd.res_load && out_valid_q && !rsp.ready), "result word overwritten before taken")
	`FCTE_ASSERT(a_one_writer, $onehot0({cmd.clr_wr, cmd.wr_set, cmd.wr_free, cmd.alloc_wr, cmd.walk_step}), "two table writers in one cycle")
	`FCTE_ASSERT(a_alloc_on_free, cmd.alloc_wr |-> rdata_s1[LINK_W-1:0] == '0, "allocate marks a used entry")
	`FCTE_ASSERT(a_walk_bound, n_q <= CNT_W'(CLUSTERS), "chain count beyond table depth")

endmodule

`default_nettype wire

[rtl/fcte_ctrl.sv]
// Controller of the FAT cluster table engine: one-hot sequencer issuing datapath commands.
// Depends on fcte_pkg and the assertion macro header.
`default_nettype none
`include "fat_cluster_table_engine_top_macros.svh"

module fcte_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  fcte_pkg::stat_t stat,
	output fcte_pkg::cmd_t  cmd
);
	import fcte_pkg::*;

	typedef enum logic [8:0] {
		S_CLEAR    = 9'b000000001,
		S_IDLE     = 9'b000000010,
		S_DECODE   = 9'b000000100,
		S_READ     = 9'b000001000,
		S_SET      = 9'b000010000,
		S_ALLOC    = 9'b000100000,
		S_WALK_CHK = 9'b001000000,
		S_WALK_DAT = 9'b010000000,
		S_RES      = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd     = '0;
		cmd.st  = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.take = 1'b1;
				if (stat.req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_RES;
				unique case (stat.op) inside
					OP_READ, OP_SET, OP_FREE: begin
						if (!stat.cl_valid) begin
							cmd.set_st = 1'b1;
							cmd.st     = ST_INVALID;
						end else if (stat.op == OP_FREE) begin
							cmd.wr_free = 1'b1;
						end else begin
							cmd.rd_cl = 1'b1;
							state_d   = (stat.op == OP_READ) ? S_READ : S_SET;
						end
					end
					OP_ALLOC: begin
						cmd.scan_rd = 1'b1;
						state_d     = S_ALLOC;
					end
					OP_FREE_CHAIN, OP_CHAIN_SIZE: begin
						state_d = S_WALK_CHK;
					end
					default: begin
						cmd.set_st = 1'b1;
						cmd.st     = ST_INVALID;
					end
				endcase
			end
			S_READ: begin
				cmd.link_cap = 1'b1;
				state_d      = S_RES;
			end
			S_SET: begin
				cmd.wr_set = 1'b1;
				state_d    = S_RES;
			end
			S_ALLOC: begin
				// one read issued per cycle, data checked in the cycle after its read
				if (stat.scan_free) begin
					cmd.alloc_wr = 1'b1;
					state_d      = S_RES;
				end else if (stat.scan_last) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_NO_FREE;
					state_d    = S_RES;
				end else begin
					cmd.scan_rd = 1'b1;
				end
			end
			S_WALK_CHK: begin
				if (stat.cur_end) begin
					state_d = S_RES;
				end else if (!stat.cur_valid) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_INVALID;
					state_d    = S_RES;
				end else if (stat.n_full) begin
					cmd.set_st = 1'b1;
					cmd.st     = ST_LOOP;
					state_d    = S_RES;
				end else begin
					cmd.walk_rd = 1'b1;
					state_d     = S_WALK_DAT;
				end
			end
			S_WALK_DAT: begin
				cmd.walk_step = 1'b1;
				state_d       = S_WALK_CHK;
			end
			S_RES: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	`FCTE_ASSERT_NEXT(a_walk_read_then_step, state_q == S_WALK_CHK && cmd.walk_rd, state_q == S_WALK_DAT && cmd.walk_step, "walk data cycle missed")

endmodule

`default_nettype wire

[rtl/fat_cluster_table_engine_top.sv]
// FAT cluster table engine, a 4096-entry on-chip FAT32 cluster table serving one operation
// per request word. Depends on fcte_pkg, fcte_if, fcte_ctrl and fcte_dpath.
`default_nettype none

// After reset the block sweeps the table to free, one entry a cycle, over all 4096 entries; req
// stays not ready meanwhile (config writes are taken at any time). Operations then use the
// table memory, with one read and one write port and registered read data: read link and set
// link read the entry in decode, then capture its link or write the new one before the result
// load; free, a bad cluster for read, set or free, and an unknown opcode go from decode straight
// to the result load. Allocate scans one entry per cycle from cluster 2, examining up to 4094
// entries. Free chain and chain size follow the chain one link at a time (read, then advance).
// The result sits in an output register; the result load waits while that register still holds
// an untaken word, and the next request is taken the cycle after the load.

module fat_cluster_table_engine_top (
	input  logic       clk,
	input  logic       arst_n,
	fcte_req_if.sink   req,
	fcte_rsp_if.source rsp,
	fcte_cfg_if.sink   cfg
);
	import fcte_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	fcte_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	fcte_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

`default_nettype wire
